### design/brgs_pkg.sv
// Shared types and constants of the bypass relay gain sequencer.
// No dependencies; imported by brgs_ramp and the top level.
`default_nettype none

package brgs_pkg;

   localparam int GAIN_FRAC_BITS = 15;
   localparam int GAIN_WIDTH     = 16;
   localparam int STEP_WIDTH     = 16;
   localparam int COUNT_WIDTH    = 16;
   localparam int CSR_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH = 2;

   typedef logic [GAIN_WIDTH-1:0]  gain_type;
   typedef logic [STEP_WIDTH-1:0]  step_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // unity gain in Q1.15
   localparam gain_type GAIN_ONE  = gain_type'(1 << GAIN_FRAC_BITS);
   localparam gain_type GAIN_ZERO = '0;

   typedef enum logic [2:0] {
      PH_OFF       = 3'd0,
      PH_SETTLING  = 3'd1,
      PH_ON        = 3'd2,
      PH_RELEASING = 3'd3,
      PH_DRAINING  = 3'd4
   } phase_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_FADE_STEP     = 2'd0,
      CSR_MUTE_STEP     = 2'd1,
      CSR_SETTLE_BLOCKS = 2'd2,
      CSR_DRAIN_BLOCKS  = 2'd3
   } csr_index_type;

   localparam step_type  FADE_STEP_RESET     = 16'd328;
   localparam step_type  MUTE_STEP_RESET     = 16'd3277;
   localparam count_type SETTLE_BLOCKS_RESET = 16'd10;
   localparam count_type DRAIN_BLOCKS_RESET  = 16'd10;

endpackage

`default_nettype wire

### design/brgs_ramp.sv
// One linear gain ramp: holds its value and steps it toward a target
// without overshoot. Depends on brgs_pkg.
`default_nettype none

module brgs_ramp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  brgs_pkg::gain_type  target,
   input  brgs_pkg::step_type  step,
   output brgs_pkg::gain_type  value,
   output brgs_pkg::gain_type  value_next
);
   import brgs_pkg::*;

   gain_type value_ff;
   gain_type value_in;
   gain_type up_dist;
   gain_type down_dist;

   assign up_dist   = target - value_ff;
   assign down_dist = value_ff - target;

   always_comb begin
      priority if (value_ff < target) begin
         value_in = (up_dist > step) ? value_ff + gain_type'(step) : target;
      end else if (value_ff > target) begin
         value_in = (down_dist > step) ? value_ff - gain_type'(step) : target;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= GAIN_ZERO;
      end else if (advance) begin
         value_ff <= value_in;
      end
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

`default_nettype wire

### design/bypass_relay_gain_sequencer_core.sv
// Top level of the bypass relay gain sequencer: input register, sequencer,
// five gain ramps and the result register. Depends on brgs_pkg, brgs_ramp.
//
// One transaction per audio block. A request is captured in an input register;
// when the result register is free, the sequencer phase, countdown and all five
// ramps are updated in a single pass and the result lands in an output register,
// and a new request can be taken in every cycle while results are taken as they
// come. While a result waits on rsp_tready, one further request is held in the
// input register and req_tready then stays low until the waiting result is taken.
// The gain path is one 16 by 16 multiply (mute times vca ramp) after the ramp
// update, which sets the cycle. Configuration writes take effect at once and
// are meant to be issued only while no transaction is in flight.
`default_nettype none

module bypass_relay_gain_sequencer_core (
   input  wire                              clock,
   input  wire                              reset,
   // request
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [15:0]                      req_tdata,  // blend
   input  wire  [3:0]                       req_tuser,  // engaged, trails, analog_dry, has_blend
   // response
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [79:0]                      rsp_tdata,  // input, wet, dry, mute, vca gains
   output logic [4:0]                       rsp_tuser,  // relay_on, phase[2:0], vca_write
   // register writes
   input  wire                              csr_we,
   input  wire  [brgs_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire  [brgs_pkg::CSR_WIDTH-1:0]   csr_wdata
);
   import brgs_pkg::*;

   // configuration
   step_type  fade_step_ff;
   step_type  mute_step_ff;
   count_type settle_blocks_ff;
   count_type drain_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_step_ff     <= FADE_STEP_RESET;
         mute_step_ff     <= MUTE_STEP_RESET;
         settle_blocks_ff <= SETTLE_BLOCKS_RESET;
         drain_blocks_ff  <= DRAIN_BLOCKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FADE_STEP:     fade_step_ff     <= step_type'(csr_wdata);
            CSR_MUTE_STEP:     mute_step_ff     <= step_type'(csr_wdata);
            CSR_SETTLE_BLOCKS: settle_blocks_ff <= count_type'(csr_wdata);
            CSR_DRAIN_BLOCKS:  drain_blocks_ff  <= count_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // input register
   logic     in_valid_ff;
   logic     engaged_ff;
   logic     trails_ff;
   logic     analog_dry_ff;
   logic     has_blend_ff;
   gain_type blend_ff;
   logic     advance;
   logic     rsp_valid_ff;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         engaged_ff    <= req_tuser[0];
         trails_ff     <= req_tuser[1];
         analog_dry_ff <= req_tuser[2];
         has_blend_ff  <= req_tuser[3];
         blend_ff      <= req_tdata;
      end
   end

   // gain targets
   gain_type blend_sat;
   gain_type wet_share;
   gain_type dry_share;
   gain_type dry_path;
   gain_type t_input;
   gain_type t_wet;
   gain_type t_dry;
   gain_type t_vca;
   gain_type t_mute;

   always_comb begin
      blend_sat = (blend_ff > GAIN_ONE) ? GAIN_ONE : blend_ff;
      wet_share = has_blend_ff ? blend_sat : GAIN_ONE;
      dry_share = has_blend_ff ? GAIN_ONE - blend_sat : GAIN_ZERO;
      dry_path  = engaged_ff ? dry_share : GAIN_ONE;
      t_input   = engaged_ff ? GAIN_ONE : GAIN_ZERO;
      t_wet     = engaged_ff ? wet_share : GAIN_ONE;
      t_vca     = analog_dry_ff ? dry_path : GAIN_ZERO;
      t_dry     = analog_dry_ff ? GAIN_ZERO : dry_path;
   end

   // relay sequencer
   phase_type phase_ff;
   phase_type phase_in;
   count_type count_ff;
   count_type count_in;
   count_type count_dec;
   logic      want_on;
   gain_type  mute_now;

   assign want_on   = engaged_ff || trails_ff;
   assign count_dec = (count_ff != '0) ? count_ff - count_type'(1) : count_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      unique case (phase_ff)
         PH_SETTLING: begin
            count_in = count_dec;
            if (count_dec == '0) phase_in = PH_ON;
         end
         PH_ON: begin
            if (!want_on) phase_in = PH_RELEASING;
         end
         PH_RELEASING: begin
            if (want_on) begin
               phase_in = PH_ON;
            end else if (mute_now == GAIN_ZERO) begin
               count_in = drain_blocks_ff;
               phase_in = PH_DRAINING;
            end
         end
         PH_DRAINING: begin
            count_in = count_dec;
            if (count_dec == '0) phase_in = PH_OFF;
         end
         default: begin
            phase_in = PH_OFF;
            if (want_on) begin
               count_in = settle_blocks_ff;
               phase_in = PH_SETTLING;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OFF;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign t_mute = (phase_in == PH_ON) ? GAIN_ONE : GAIN_ZERO;

   // ramps
   gain_type input_now, input_next;
   gain_type wet_now, wet_next;
   gain_type dry_now, dry_next;
   gain_type vca_now, vca_next;
   gain_type mute_next;

   brgs_ramp u_input_ramp (
      .clock(clock), .reset(reset), .advance(advance),
      .target(t_input), .step(fade_step_ff), .value(input_now), .value_next(input_next)
   );
   brgs_ramp u_wet_ramp (
      .clock(clock), .reset(reset), .advance(advance),
      .target(t_wet), .step(fade_step_ff), .value(wet_now), .value_next(wet_next)
   );
   brgs_ramp u_dry_ramp (
      .clock(clock), .reset(reset), .advance(advance),
      .target(t_dry), .step(fade_step_ff), .value(dry_now), .value_next(dry_next)
   );
   brgs_ramp u_vca_ramp (
      .clock(clock), .reset(reset), .advance(advance),
      .target(t_vca), .step(fade_step_ff), .value(vca_now), .value_next(vca_next)
   );
   brgs_ramp u_mute_ramp (
      .clock(clock), .reset(reset), .advance(advance),
      .target(t_mute), .step(mute_step_ff), .value(mute_now), .value_next(mute_next)
   );

   // vca product and write strobe
   logic [2*GAIN_WIDTH-1:0] vca_product;
   gain_type                vca_gain;
   gain_type                last_vca_ff;
   logic                    vca_write;

   assign vca_product = (2*GAIN_WIDTH)'(mute_next) * (2*GAIN_WIDTH)'(vca_next);
   assign vca_gain    = vca_product[GAIN_FRAC_BITS +: GAIN_WIDTH];
   assign vca_write   = (vca_gain != last_vca_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_vca_ff <= GAIN_ZERO;
      end else if (advance && vca_write) begin
         last_vca_ff <= vca_gain;
      end
   end

   // result register
   logic [79:0] rsp_data_ff;
   logic [4:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {vca_gain, mute_next, dry_next, wet_next, input_next};
         rsp_user_ff <= {vca_write, phase_in, (phase_in != PH_OFF)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // mute stays closed outside the on and releasing phases
   a_mute_closed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OFF || phase_ff == PH_SETTLING || phase_ff == PH_DRAINING)
      |-> mute_now == GAIN_ZERO)
      else $error("mute gain open while relays not settled");

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten");

   // a strobed vca value is the one remembered as last written
   a_vca_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[4]) |-> rsp_data_ff[79:64] == last_vca_ff)
      else $error("vca strobe out of step with last written value");

   // ramps never pass unity
   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      input_now <= GAIN_ONE && wet_now <= GAIN_ONE && dry_now <= GAIN_ONE
      && vca_now <= GAIN_ONE && mute_now <= GAIN_ONE)
      else $error("gain ramp above unity");

endmodule

`default_nettype wire
